// File: rtl/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg: shared types and constants of the nearest-neighbor scaler
// Field widths, operation and register codes, and the divider request and
// response bundles.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int CH_W       = 8;                 // one color channel
  localparam int PIX_W      = 3 * CH_W;          // packed RGB entry
  localparam int DIM_W      = 9;                 // source width / height
  localparam int SCALE_W    = 12;                // Q4.8 scale
  localparam int FRAC_W     = 8;                 // fraction bits of the scale
  localparam int PROD_W     = DIM_W + SCALE_W;   // shared multiplier result
  localparam int SIZE_W     = PROD_W - FRAC_W;   // scaled output size
  localparam int POS_W      = 12;                // stored output row / column
  localparam int WPOS_W     = POS_W + 1;         // working row may reach 4096
  localparam int QUO_W      = DIM_W;             // divider quotient bits
  localparam int CNT_W      = $clog2(QUO_W);
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = SCALE_W;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_SCALE      = 2'd2
  } cfg_addr_e;

  typedef struct packed {
    logic              start;
    logic [WPOS_W-1:0] pos;
    logic [DIM_W-1:0]  limit;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] idx;
  } div_rsp_t;

endpackage

// File: rtl/nnis_if.sv
// ----------------------------------------------------------------------------
// nnis_if: valid/ready channels of the nearest-neighbor scaler
// Input beat, output beat and register write channel.
// ----------------------------------------------------------------------------
interface nnis_in_if import nnis_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      op;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, op, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface nnis_out_if import nnis_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            last;
  logic            no_image;

  modport source (output valid, red_out, green_out, blue_out, last, no_image,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last, no_image,
                  output ready);
endinterface

interface nnis_cfg_if import nnis_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/nearest_neighbour_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_image_scaler: nearest-neighbor scaler over a stored frame
// Load, restart and read beats over one stored RGB frame, scaled by Q4.8.
// ----------------------------------------------------------------------------
// Load and restart beats stay in idle; the next beat is taken in the next cycle.
// A read beat runs through the output-size states and then two shared-divider
// passes (row index, then column index) before its result; an empty output
// frame skips both passes. No beat is taken meanwhile.
// Reset clears positions, sets 256x256 source and unity scale; frame contents
// stay undefined until loaded.
module nearest_neighbour_image_scaler import nnis_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nnis_cfg_if.sink   cfg_i,
  nnis_in_if.sink    in_i,
  nnis_out_if.source out_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LPW   = $clog2(DEPTH + 1);

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // take a beat
  localparam logic [2:0] S_OW   = 3'd1;  // output width
  localparam logic [2:0] S_OH   = 3'd2;  // output height
  localparam logic [2:0] S_FIX  = 3'd3;  // wrap stale position, start row divide
  localparam logic [2:0] S_ROW  = 3'd4;  // wait for row index, start column divide
  localparam logic [2:0] S_COL  = 3'd5;  // wait for column index
  localparam logic [2:0] S_ADDR = 3'd6;  // form address, read frame, step position
  localparam logic [2:0] S_RD   = 3'd7;  // hand result to the output register

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [DIM_W-1:0]   src_width_q;
  logic [DIM_W-1:0]   src_height_q;
  logic [SCALE_W-1:0] scale_q;

  // Positions
  logic [LPW-1:0]   load_pos_q;
  logic [POS_W-1:0] out_row_q;
  logic [POS_W-1:0] out_col_q;

  // Per-read working values
  logic [SIZE_W-1:0] ow_q;
  logic [SIZE_W-1:0] oh_q;
  logic [WPOS_W-1:0] wrow_q;
  logic [POS_W-1:0]  wcol_q;
  logic [DIM_W-1:0]  srow_q;
  logic [DIM_W-1:0]  scol_q;
  logic              empty_q;
  logic              last_q;

  // Output register
  logic            out_valid_q;
  logic [CH_W-1:0] red_q, green_q, blue_q;
  logic            out_last_q;
  logic            no_image_q;

  // Frame store
  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    raddr;

  // Effective source size: clamp to the stored frame
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;

  assign eff_w = (32'(src_width_q)  > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : src_width_q;
  assign eff_h = (32'(src_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : src_height_q;

  // Shared multiplier: frame area while idle, output sizes, then row offset
  logic [DIM_W-1:0]   mul_a;
  logic [SCALE_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]  size_sum;
  logic [PROD_W-1:0]  addr_sum;

  always_comb begin
    mul_a = eff_w;
    mul_b = SCALE_W'(eff_h);
    case (state_q)
      S_OW: begin
        mul_a = eff_w;
        mul_b = scale_q;
      end
      S_OH: begin
        mul_a = eff_h;
        mul_b = scale_q;
      end
      S_ADDR: begin
        mul_a = srow_q;
        mul_b = SCALE_W'(eff_w);
      end
      default: begin
        mul_a = eff_w;
        mul_b = SCALE_W'(eff_h);
      end
    endcase
  end

  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign size_sum = mul_p + PROD_W'(ROUND_HALF);
  assign addr_sum = mul_p + PROD_W'(scol_q);
  assign raddr    = AW'(addr_sum);

  // Beat handshakes
  logic in_fire;
  logic out_free;
  logic load_ok;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // Drop loads past the frame
  assign load_ok = (32'(load_pos_q) < 32'(mul_p));
  assign mem_we  = in_fire && (in_i.op == OP_LOAD) && load_ok;
  assign mem_re  = (state_q == S_ADDR);

  // Wrap a stale position before the fetch
  logic              col_wrap;
  logic [POS_W-1:0]  fix_col;
  logic [WPOS_W-1:0] fix_row_inc;
  logic [WPOS_W-1:0] fix_row;
  logic              empty;

  assign empty       = (ow_q == '0) || (oh_q == '0);
  assign col_wrap    = ({1'b0, out_col_q} >= ow_q);
  assign fix_col     = col_wrap ? '0 : out_col_q;
  assign fix_row_inc = col_wrap ? ({1'b0, out_row_q} + 1'b1) : {1'b0, out_row_q};
  assign fix_row     = (fix_row_inc >= oh_q) ? '0 : fix_row_inc;

  // Next position after the fetched pixel
  logic              is_last;
  logic              row_end;
  logic [SIZE_W-1:0] col_inc;

  assign col_inc = {1'b0, wcol_q} + 1'b1;
  assign is_last = (wrow_q == (oh_q - 1'b1)) && ({1'b0, wcol_q} == (ow_q - 1'b1));
  assign row_end = (col_inc >= ow_q);

  // Shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req.start = 1'b0;
    div_req.pos   = fix_row;
    div_req.limit = eff_h;
    case (state_q)
      S_FIX: begin
        div_req.start = !empty;
      end
      S_ROW: begin
        div_req.start = div_rsp.done;
        div_req.pos   = {1'b0, wcol_q};
        div_req.limit = eff_w;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  nnis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scale_i (scale_q),
    .req_i   (div_req),
    .rsp_o   (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire && (in_i.op == OP_READ)) state_d = S_OW;
      S_OW:   state_d = S_OH;
      S_OH:   state_d = S_FIX;
      S_FIX:  state_d = empty ? S_RD : S_ROW;
      S_ROW:  if (div_rsp.done) state_d = S_COL;
      S_COL:  if (div_rsp.done) state_d = S_ADDR;
      S_ADDR: state_d = S_RD;
      S_RD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      src_width_q  <= DIM_W'(256);
      src_height_q <= DIM_W'(256);
      scale_q      <= SCALE_W'(256);
      load_pos_q   <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes; unknown addresses fall away
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.addr)
          CFG_SRC_WIDTH:  src_width_q  <= cfg_i.data[DIM_W-1:0];
          CFG_SRC_HEIGHT: src_height_q <= cfg_i.data[DIM_W-1:0];
          CFG_SCALE:      scale_q      <= cfg_i.data;
          default: ;
        endcase
      end

      if (in_fire) begin
        case (in_i.op)
          OP_LOAD: if (load_ok) load_pos_q <= load_pos_q + 1'b1;
          OP_RESTART: begin
            load_pos_q <= '0;
            out_row_q  <= '0;
            out_col_q  <= '0;
          end
          default: ;
        endcase
      end

      // Advance the output position; the final pixel wraps to the origin
      if (state_q == S_ADDR) begin
        if (is_last) begin
          out_row_q <= '0;
          out_col_q <= '0;
        end else if (row_end) begin
          out_row_q <= wrow_q[POS_W-1:0] + 1'b1;
          out_col_q <= '0;
        end else begin
          out_row_q <= wrow_q[POS_W-1:0];
          out_col_q <= wcol_q + 1'b1;
        end
      end

      if (state_q == S_RD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_OW) ow_q <= size_sum[PROD_W-1:FRAC_W];
    if (state_q == S_OH) oh_q <= size_sum[PROD_W-1:FRAC_W];
    if (state_q == S_FIX) begin
      empty_q <= empty;
      wrow_q  <= fix_row;
      wcol_q  <= fix_col;
    end
    if (state_q == S_ROW && div_rsp.done) srow_q <= div_rsp.idx;
    if (state_q == S_COL && div_rsp.done) scol_q <= div_rsp.idx;
    if (state_q == S_ADDR) last_q <= is_last;
    if (state_q == S_RD && out_free) begin
      red_q      <= empty_q ? '0 : rdata_q[PIX_W-1:2*CH_W];
      green_q    <= empty_q ? '0 : rdata_q[2*CH_W-1:CH_W];
      blue_q     <= empty_q ? '0 : rdata_q[CH_W-1:0];
      out_last_q <= empty_q ? 1'b0 : last_q;
      no_image_q <= empty_q;
    end
  end

  // Frame store: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[AW'(load_pos_q)] <= {in_i.red_in, in_i.green_in, in_i.blue_in};
    end
    if (mem_re) begin
      rdata_q <= frame_mem[raddr];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.red_out   = red_q;
  assign out_o.green_out = green_q;
  assign out_o.blue_out  = blue_q;
  assign out_o.last      = out_last_q;
  assign out_o.no_image  = no_image_q;

endmodule

// File: rtl/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div: iterative source-index divider
// Computes min(floor(pos*256/scale), limit-1), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_div import nnis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SCALE_W-1:0] scale_i,
  input  div_req_t           req_i,
  output div_rsp_t           rsp_o
);

  logic               run_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SCALE_W-1:0] rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic               sat_q;
  logic               lsb_q;
  logic [DIM_W-1:0]   limit_q;

  logic [SCALE_W:0]   trial;
  logic [SCALE_W:0]   diff;
  logic               ge;
  logic               sat_d;

  // Dividend is pos followed by eight zero bits; its top bits seed the remainder.
  assign trial = {rem_q, (cnt_q == CNT_W'(QUO_W - 1)) ? lsb_q : 1'b0};
  assign ge    = (trial >= {1'b0, scale_i});
  assign diff  = trial - {1'b0, scale_i};

  // Quotient of 512 or more always clamps.
  assign sat_d = ({1'b0, req_i.pos} >= {1'b0, scale_i, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && run_q && (cnt_q == '0);
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(QUO_W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q   <= req_i.pos[WPOS_W-1:1];
      lsb_q   <= req_i.pos[0];
      sat_q   <= sat_d;
      limit_q <= req_i.limit;
      quo_q   <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[QUO_W-2:0], ge};
      rem_q <= ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.idx  = (sat_q || (quo_q >= limit_q)) ? (limit_q - 1'b1) : quo_q;

endmodule
